@@ rtl/psp_pkg.sv @@
package psp_pkg;

    // Filter coefficient is Q0.16
    localparam int ALPHA_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BUS_CNT_W  = 16;
    localparam int OVER_CNT_W = 8;
    localparam int CUR_W      = 13;

    localparam logic signed [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
    localparam logic signed [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};

    localparam logic [ALPHA_W-1:0]    RST_ALPHA     = 16'd655;
    localparam logic [BUS_CNT_W-1:0]  RST_BUS_DELAY = 16'd5000;
    localparam logic [OVER_CNT_W-1:0] RST_CUR_DELAY = 8'd5;
    localparam int                    RST_OFS_TOL   = 248;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ALPHA     = 3'd0,
        CFG_BUS_LOW_LIMIT    = 3'd1,
        CFG_BUS_HIGH_LIMIT   = 3'd2,
        CFG_BUS_FAULT_DELAY  = 3'd3,
        CFG_OFFSET_EXPECTED  = 3'd4,
        CFG_OFFSET_TOLERANCE = 3'd5,
        CFG_CURRENT_LIMIT    = 3'd6,
        CFG_CUR_FAULT_DELAY  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_BUS     = 2'd1,
        FAULT_OFFSET  = 2'd2,
        FAULT_OVERCUR = 2'd3
    } t_fault;

    typedef struct packed {
        logic pass;
        logic fail;
    } t_cal_evt;

endpackage

@@ rtl/psp_bus_mon.sv @@
module psp_bus_mon #(
    parameter int ADC_BITS         = 12,
    parameter int FILTER_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic [ADC_BITS-1:0]                  i_vb,
    input  logic [psp_pkg::ALPHA_W-1:0]          i_alpha,
    input  logic [ADC_BITS-1:0]                  i_low,
    input  logic [ADC_BITS-1:0]                  i_high,
    input  logic [psp_pkg::BUS_CNT_W-1:0]        i_delay,
    output logic [ADC_BITS+FILTER_FRAC_BITS-1:0] o_acc,
    output logic                                 o_fire
);
    import psp_pkg::*;

    localparam int AW = ADC_BITS + FILTER_FRAC_BITS;
    localparam int DW = AW + 1;
    localparam int PW = DW + ALPHA_W + 1;
    localparam logic [AW-1:0] ACC_MAX = '1;

    logic [AW-1:0]            r_acc;
    logic [AW-1:0]            n_acc;
    logic [BUS_CNT_W-1:0]     r_bad_cnt;
    logic [BUS_CNT_W-1:0]     n_bad_cnt;
    logic signed [DW-1:0]     diff;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     step;
    logic signed [PW-1:0]     sum;
    logic                     outside;

    always_comb begin
        diff = $signed({1'b0, i_vb, {FILTER_FRAC_BITS{1'b0}}}) - $signed({1'b0, r_acc});
        prod = $signed({1'b0, i_alpha}) * diff;
        // arithmetic shift floors toward minus infinity
        step = prod >>> ALPHA_W;
        sum  = $signed(PW'(r_acc)) + step;
        if (sum[PW-1]) begin
            n_acc = '0;
        end else if (|sum[PW-2:AW]) begin
            n_acc = ACC_MAX;
        end else begin
            n_acc = sum[AW-1:0];
        end

        outside = (n_acc < {i_low, {FILTER_FRAC_BITS{1'b0}}}) ||
                  (n_acc > {i_high, {FILTER_FRAC_BITS{1'b0}}});
        if (!outside) begin
            n_bad_cnt = '0;
        end else if (r_bad_cnt != '1) begin
            n_bad_cnt = r_bad_cnt + 1'b1;
        end else begin
            n_bad_cnt = r_bad_cnt;
        end
        o_fire = outside && (n_bad_cnt > i_delay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_bad_cnt <= '0;
        end else if (i_en) begin
            r_acc     <= n_acc;
            r_bad_cnt <= n_bad_cnt;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/psp_offset_cal.sv @@
module psp_offset_cal #(
    parameter int ADC_BITS        = 12,
    parameter int DISCARD_SAMPLES = 99,
    parameter int AVERAGE_SAMPLES = 100
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_mode,
    input  logic [ADC_BITS-1:0]                          i_pa,
    input  logic [ADC_BITS-1:0]                          i_pb,
    input  logic [ADC_BITS+$clog2(AVERAGE_SAMPLES)-1:0]  i_exp_n,
    input  logic [ADC_BITS+$clog2(AVERAGE_SAMPLES)-1:0]  i_tol_n,
    output logic [ADC_BITS-1:0]                          o_offset_a,
    output logic [ADC_BITS-1:0]                          o_offset_b,
    output psp_pkg::t_cal_evt                            o_evt
);
    import psp_pkg::*;

    localparam int CAL_END = DISCARD_SAMPLES + AVERAGE_SAMPLES;
    localparam int CNT_W   = $clog2(CAL_END + 1);
    localparam int SUM_W   = ADC_BITS + $clog2(AVERAGE_SAMPLES);
    localparam int XW      = SUM_W + 1;
    localparam int SH      = XW + $clog2(AVERAGE_SAMPLES);
    localparam int MW      = XW + 1;
    localparam int HALF    = AVERAGE_SAMPLES / 2;
    // ceil(2^SH / N): exact quotient for every dividend below 2^XW
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [SUM_W-1:0]        r_sum_a;
    logic [SUM_W-1:0]        r_sum_b;
    logic [SUM_W-1:0]        n_sum_a;
    logic [SUM_W-1:0]        n_sum_b;
    logic [ADC_BITS-1:0]     r_offset_a;
    logic [ADC_BITS-1:0]     r_offset_b;
    logic                    add_en;
    logic                    cal_end;
    logic [XW+MW-1:0]        prod_a;
    logic [XW+MW-1:0]        prod_b;
    logic signed [XW-1:0]    dev_a;
    logic signed [XW-1:0]    dev_b;
    logic [XW-1:0]           mag_a;
    logic [XW-1:0]           mag_b;
    logic                    bad;

    always_comb begin
        n_count = (r_count < CNT_W'(CAL_END)) ? r_count + 1'b1 : r_count;
        add_en  = n_count > CNT_W'(DISCARD_SAMPLES);
        cal_end = n_count >= CNT_W'(CAL_END);
        n_sum_a = r_sum_a + (add_en ? SUM_W'(i_pa) : '0);
        n_sum_b = r_sum_b + (add_en ? SUM_W'(i_pb) : '0);

        // rounded average by reciprocal multiply
        prod_a = (XW+MW)'(XW'(n_sum_a) + XW'(HALF)) * (XW+MW)'(MW'(RECIP));
        prod_b = (XW+MW)'(XW'(n_sum_b) + XW'(HALF)) * (XW+MW)'(MW'(RECIP));

        dev_a = $signed({1'b0, n_sum_a}) - $signed({1'b0, i_exp_n});
        dev_b = $signed({1'b0, n_sum_b}) - $signed({1'b0, i_exp_n});
        mag_a = dev_a[XW-1] ? XW'(-dev_a) : XW'(dev_a);
        mag_b = dev_b[XW-1] ? XW'(-dev_b) : XW'(dev_b);
        bad   = (mag_a > {1'b0, i_tol_n}) || (mag_b > {1'b0, i_tol_n});

        o_evt.pass = !i_mode && cal_end && !bad;
        o_evt.fail = !i_mode && cal_end && bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
            r_offset_a <= '0;
            r_offset_b <= '0;
        end else if (i_en) begin
            if (i_mode || cal_end) begin
                // a run sample restarts an unfinished round
                r_count <= '0;
                r_sum_a <= '0;
                r_sum_b <= '0;
            end else begin
                r_count <= n_count;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
            end
            if (!i_mode && cal_end) begin
                r_offset_a <= prod_a[SH +: ADC_BITS];
                r_offset_b <= prod_b[SH +: ADC_BITS];
            end
        end
    end

    assign o_offset_a = r_offset_a;
    assign o_offset_b = r_offset_b;

endmodule

@@ rtl/psp_curr_chk.sv @@
module psp_curr_chk #(
    parameter int ADC_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_mode,
    input  logic [ADC_BITS-1:0]                 i_pa,
    input  logic [ADC_BITS-1:0]                 i_pb,
    input  logic [ADC_BITS-1:0]                 i_offset_a,
    input  logic [ADC_BITS-1:0]                 i_offset_b,
    input  logic [ADC_BITS-1:0]                 i_limit,
    input  logic [psp_pkg::OVER_CNT_W-1:0]      i_delay,
    output logic signed [psp_pkg::CUR_W-1:0]    o_cur_a,
    output logic signed [psp_pkg::CUR_W-1:0]    o_cur_b,
    output logic                                o_fire
);
    import psp_pkg::*;

    localparam int DW    = (ADC_BITS + 1 > CUR_W) ? ADC_BITS + 1 : CUR_W;
    localparam int CMP_W = (ADC_BITS > CUR_W) ? ADC_BITS : CUR_W;

    logic [OVER_CNT_W-1:0]     r_over_cnt;
    logic [OVER_CNT_W-1:0]     n_over_cnt;
    logic signed [CUR_W-1:0]   cur_a;
    logic signed [CUR_W-1:0]   cur_b;
    logic                      over;

    function automatic logic signed [CUR_W-1:0] sub_clamp(
        input logic [ADC_BITS-1:0] count,
        input logic [ADC_BITS-1:0] offset
    );
        logic signed [DW-1:0] d;
        d = $signed(DW'(count)) - $signed(DW'(offset));
        if (d > DW'(CUR_MAX)) begin
            return CUR_MAX;
        end else if (d < DW'(CUR_MIN)) begin
            return CUR_MIN;
        end
        return CUR_W'(d);
    endfunction

    function automatic logic [CMP_W-1:0] mag(input logic signed [CUR_W-1:0] v);
        return v[CUR_W-1] ? CMP_W'(CUR_W'(-v)) : CMP_W'(v);
    endfunction

    always_comb begin
        cur_a = sub_clamp(i_pa, i_offset_a);
        cur_b = sub_clamp(i_pb, i_offset_b);
        over  = (mag(cur_a) > CMP_W'(i_limit)) || (mag(cur_b) > CMP_W'(i_limit));

        if (!i_mode) begin
            // count is kept across calibrate samples
            n_over_cnt = r_over_cnt;
        end else if (!over) begin
            n_over_cnt = '0;
        end else if (r_over_cnt != '1) begin
            n_over_cnt = r_over_cnt + 1'b1;
        end else begin
            n_over_cnt = r_over_cnt;
        end

        o_fire  = i_mode && over && (n_over_cnt > i_delay);
        o_cur_a = i_mode ? cur_a : '0;
        o_cur_b = i_mode ? cur_b : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_cnt <= '0;
        end else if (i_en) begin
            r_over_cnt <= n_over_cnt;
        end
    end

endmodule

@@ rtl/phase_current_sense_protect_top.sv @@
// Phase current sensing with ADC offset calibration and fault protection.
// Each sample passes through the input register, then the result register.
// Throughput: one sample per clock while the output is not stalled; the bus
// filter feedback through a single 17 x 29 multiply sets the cycle.
// Synchronous active-low reset restores register defaults and clears filter,
// offsets, counters and the fault latch.
module phase_current_sense_protect_top #(
    parameter int ADC_BITS         = 12,
    parameter int DISCARD_SAMPLES  = 99,
    parameter int AVERAGE_SAMPLES  = 100,
    parameter int FILTER_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // adc_phase_a, adc_phase_b, adc_bus
    input  logic [((3*ADC_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    // mode
    input  logic                                  i_s_axis_tuser,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // bus_filtered, current_a, current_b, fault_code, calibrated
    output logic [((ADC_BITS+FILTER_FRAC_BITS+2*psp_pkg::CUR_W+3+7)/8)*8-1:0]
                                                  o_m_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    input  logic                                  i_cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [psp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import psp_pkg::*;

    localparam int AW       = ADC_BITS + FILTER_FRAC_BITS;
    localparam int SUM_W    = ADC_BITS + $clog2(AVERAGE_SAMPLES);
    localparam int OUT_W    = AW + 2 * CUR_W + 3;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;
    localparam logic [SUM_W-1:0] RST_EXP_N = SUM_W'(AVERAGE_SAMPLES) << (ADC_BITS - 1);
    localparam logic [SUM_W-1:0] RST_TOL_N = SUM_W'(RST_OFS_TOL * AVERAGE_SAMPLES);

    // configuration
    logic [ALPHA_W-1:0]     r_alpha;
    logic [ADC_BITS-1:0]    r_bus_low;
    logic [ADC_BITS-1:0]    r_bus_high;
    logic [BUS_CNT_W-1:0]   r_bus_delay;
    logic [SUM_W-1:0]       r_exp_n;
    logic [SUM_W-1:0]       r_tol_n;
    logic [ADC_BITS-1:0]    r_cur_limit;
    logic [OVER_CNT_W-1:0]  r_cur_delay;

    // input register
    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [ADC_BITS-1:0]    r_in_pa;
    logic [ADC_BITS-1:0]    r_in_pb;
    logic [ADC_BITS-1:0]    r_in_vb;

    // result register and latched status
    logic                   r_out_valid;
    logic signed [CUR_W-1:0] r_cur_a;
    logic signed [CUR_W-1:0] r_cur_b;
    t_fault                 r_fault;
    t_fault                 n_fault;
    logic                   r_cal_done;

    logic                   advance;
    logic [AW-1:0]          acc;
    logic                   bus_fire;
    logic [ADC_BITS-1:0]    offset_a;
    logic [ADC_BITS-1:0]    offset_b;
    t_cal_evt               cal_evt;
    logic signed [CUR_W-1:0] cur_a;
    logic signed [CUR_W-1:0] cur_b;
    logic                   cur_fire;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TD_W'({r_cal_done, r_fault, r_cur_b, r_cur_a, acc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= RST_ALPHA;
            r_bus_low   <= '0;
            r_bus_high  <= '1;
            r_bus_delay <= RST_BUS_DELAY;
            r_exp_n     <= RST_EXP_N;
            r_tol_n     <= RST_TOL_N;
            r_cur_limit <= '1;
            r_cur_delay <= RST_CUR_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_ALPHA:     r_alpha     <= i_cfg_wdata[ALPHA_W-1:0];
                CFG_BUS_LOW_LIMIT:    r_bus_low   <= i_cfg_wdata[ADC_BITS-1:0];
                CFG_BUS_HIGH_LIMIT:   r_bus_high  <= i_cfg_wdata[ADC_BITS-1:0];
                CFG_BUS_FAULT_DELAY:  r_bus_delay <= i_cfg_wdata[BUS_CNT_W-1:0];
                // keep expected and tolerance scaled by the average length
                CFG_OFFSET_EXPECTED:  r_exp_n <= SUM_W'(i_cfg_wdata[ADC_BITS-1:0]) *
                                                 SUM_W'(AVERAGE_SAMPLES);
                CFG_OFFSET_TOLERANCE: r_tol_n <= SUM_W'(i_cfg_wdata[ADC_BITS-1:0]) *
                                                 SUM_W'(AVERAGE_SAMPLES);
                CFG_CURRENT_LIMIT:    r_cur_limit <= i_cfg_wdata[ADC_BITS-1:0];
                CFG_CUR_FAULT_DELAY:  r_cur_delay <= i_cfg_wdata[OVER_CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_mode <= i_s_axis_tuser;
            r_in_pa   <= i_s_axis_tdata[ADC_BITS-1:0];
            r_in_pb   <= i_s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
            r_in_vb   <= i_s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS];
        end
    end

    psp_bus_mon #(
        .ADC_BITS         (ADC_BITS),
        .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
    ) u_bus_mon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_vb    (r_in_vb),
        .i_alpha (r_alpha),
        .i_low   (r_bus_low),
        .i_high  (r_bus_high),
        .i_delay (r_bus_delay),
        .o_acc   (acc),
        .o_fire  (bus_fire)
    );

    psp_offset_cal #(
        .ADC_BITS        (ADC_BITS),
        .DISCARD_SAMPLES (DISCARD_SAMPLES),
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_offset_cal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_mode     (r_in_mode),
        .i_pa       (r_in_pa),
        .i_pb       (r_in_pb),
        .i_exp_n    (r_exp_n),
        .i_tol_n    (r_tol_n),
        .o_offset_a (offset_a),
        .o_offset_b (offset_b),
        .o_evt      (cal_evt)
    );

    psp_curr_chk #(
        .ADC_BITS (ADC_BITS)
    ) u_curr_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_mode     (r_in_mode),
        .i_pa       (r_in_pa),
        .i_pb       (r_in_pb),
        .i_offset_a (offset_a),
        .i_offset_b (offset_b),
        .i_limit    (r_cur_limit),
        .i_delay    (r_cur_delay),
        .o_cur_a    (cur_a),
        .o_cur_b    (cur_b),
        .o_fire     (cur_fire)
    );

    // overcurrent wins over an offset failure, which wins over a bus fault
    always_comb begin
        priority if (cur_fire) begin
            n_fault = FAULT_OVERCUR;
        end else if (cal_evt.fail) begin
            n_fault = FAULT_OFFSET;
        end else if (bus_fire) begin
            n_fault = FAULT_BUS;
        end else begin
            n_fault = r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fault     <= FAULT_NONE;
            r_cal_done  <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_fault     <= n_fault;
            r_cal_done  <= r_cal_done || cal_evt.pass;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cur_a <= cur_a;
            r_cur_b <= cur_b;
        end
    end

`ifndef SYNTH
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != FAULT_NONE) |=> (r_fault != FAULT_NONE))
        else $error("fault latch cleared without reset");

    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_done |=> r_cal_done)
        else $error("calibrated flag dropped");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_cal_zero_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_mode) |=> (r_cur_a == '0 && r_cur_b == '0))
        else $error("nonzero current on a calibrate sample");

    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("result valid without a transfer from the input stage");
`endif

endmodule
